// ----- design/vfcao_pkg.sv -----
// vfcao_pkg: shared constants, types and functions for the voxel face culler.
// Depends on nothing.
package vfcao_pkg;
	localparam int ChunkEdge = 16;
	localparam int PadSide   = ChunkEdge + 2;
	localparam int CoordW    = 5;
	localparam int RowDepth  = PadSide * PadSide;
	localparam int AddrW     = $clog2(RowDepth);
	localparam int QDepth    = 2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_MESH  = 1'b1;

	typedef struct packed {
		logic              mesh;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] z;
		logic              fill;
	} cmd_t;

	// 27-cell neighbourhood, index (dy*3+dz)*3+dx with d in 0..2 meaning -1..+1
	typedef logic [26:0] nbh_t;

	function automatic logic nbh_bit(input nbh_t n, input int dx, input int dy,
			input int dz);
		return n[(dy*3+dz)*3+dx];
	endfunction

	function automatic logic [1:0] ao_lvl(input logic s1, input logic s2, input logic c);
		logic [1:0] sum;
		sum = {1'b0, s1} + {1'b0, s2} + {1'b0, c};
		return (s1 && s2) ? 2'd0 : 2'd3 - sum;
	endfunction
endpackage

// ----- design/vfcao_ram.sv -----
// vfcao_ram: generic single-port RAM with registered read.
// Depends on nothing.
module vfcao_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- design/vfcao_front.sv -----
// vfcao_front: accepts words, drops requests that can yield nothing, queues the rest.
// Depends on vfcao_pkg.
module vfcao_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  logic              mode,
	input  logic [4:0]        vox_x,
	input  logic [4:0]        vox_y,
	input  logic [4:0]        vox_z,
	input  logic              filled,
	output logic              q_valid,
	output vfcao_pkg::cmd_t   q_cmd,
	input  logic              q_pop
);
	import vfcao_pkg::*;

	cmd_t            slot_q [QDepth];
	logic            rd_q, wr_q;
	logic [1:0]      cnt_q;
	logic            keep;
	logic            in_grid, in_chunk;
	cmd_t            cmd;

	assign in_grid  = (vox_x < CoordW'(PadSide)) && (vox_y < CoordW'(PadSide))
		&& (vox_z < CoordW'(PadSide));
	assign in_chunk = (vox_x != '0) && (vox_y != '0) && (vox_z != '0)
		&& (vox_x <= CoordW'(ChunkEdge)) && (vox_y <= CoordW'(ChunkEdge))
		&& (vox_z <= CoordW'(ChunkEdge));
	assign keep  = (mode == MODE_WRITE) ? in_grid : in_chunk;
	assign cmd   = '{mesh: mode, x: vox_x, y: vox_y, z: vox_z, fill: filled};
	assign stall = (cnt_q == 2'(QDepth));
	assign q_valid = (cnt_q != '0);
	assign q_cmd   = slot_q[rd_q];

	logic push;
	assign push = valid && !stall && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ----- design/vfcao_back.sv -----
// vfcao_back: row clearing, writes, 3x3 row gather and per-face emission.
// Depends on vfcao_pkg and vfcao_ram.
module vfcao_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  vfcao_pkg::cmd_t   q_cmd,
	output logic              q_pop,
	output logic              valid,
	input  logic              stall,
	output logic [2:0]        face_id,
	output logic [1:0]        ao_top_left,
	output logic [1:0]        ao_bottom_left,
	output logic [1:0]        ao_bottom_right,
	output logic [1:0]        ao_top_right,
	output logic              split_flip,
	output logic [4:0]        face_x,
	output logic [4:0]        face_y,
	output logic [4:0]        face_z,
	output logic              last_face
);
	import vfcao_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_WRMOD = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [AddrW-1:0]  clr_q;
	logic [3:0]        rcnt_q;
	cmd_t              cmd_q;
	nbh_t              nbh_q;
	logic [5:0]        todo_q;
	logic [2:0]        face_q;

	logic              we;
	logic [AddrW-1:0]  addr;
	logic [PadSide-1:0] wdata, rdata;

	vfcao_ram #(.Width(PadSide), .Depth(RowDepth)) u_rows (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	function automatic logic [AddrW-1:0] row_addr(input logic [CoordW-1:0] y,
			input logic [CoordW-1:0] z);
		logic [AddrW+CoordW-1:0] p;
		p = (AddrW+CoordW)'(y) * (AddrW+CoordW)'(PadSide) + (AddrW+CoordW)'(z);
		return p[AddrW-1:0];
	endfunction

	// read r (0..8) fetches row dy=r/3, dz=r%3 around the voxel
	logic [1:0] rdy, rdz;
	always_comb begin
		unique case (rcnt_q)
			4'd0, 4'd1, 4'd2: rdy = 2'd0;
			4'd3, 4'd4, 4'd5: rdy = 2'd1;
			default:          rdy = 2'd2;
		endcase
		unique case (rcnt_q)
			4'd0, 4'd3, 4'd6: rdz = 2'd0;
			4'd1, 4'd4, 4'd7: rdz = 2'd1;
			default:          rdz = 2'd2;
		endcase
	end

	logic [CoordW-1:0] ry, rz;
	assign ry = cmd_q.y + CoordW'(rdy) - CoordW'(1);
	assign rz = cmd_q.z + CoordW'(rdz) - CoordW'(1);

	// previous read index arrives in rdata this cycle
	logic [3:0] prev;
	assign prev = rcnt_q - 4'd1;
	logic [2:0] bits3;
	assign bits3 = 3'(rdata >> (cmd_q.x - CoordW'(1)));

	logic wr_now;
	assign wr_now = (state_q == S_WRMOD);
	always_comb begin
		we    = 1'b0;
		addr  = row_addr(cmd_q.y, cmd_q.z);
		wdata = rdata;
		priority case (1'b1)
			state_q == S_CLEAR: begin
				we = 1'b1; addr = clr_q; wdata = '0;
			end
			state_q == S_IDLE: begin
				addr = row_addr(q_cmd.y, q_cmd.z);
			end
			wr_now: begin
				we = 1'b1;
				wdata[cmd_q.x] = cmd_q.fill;
			end
			state_q == S_READ: addr = row_addr(ry, rz);
			default: ;
		endcase
	end

	// face evaluation for the current face
	logic s0,s1,s2,s3,s4,s5,s6,s7,s8,s9,s10,s11;
	logic [1:0] l0, l1, l2, l3;
	always_comb begin
		s0=1'b0;s1=1'b0;s2=1'b0;s3=1'b0;s4=1'b0;s5=1'b0;
		s6=1'b0;s7=1'b0;s8=1'b0;s9=1'b0;s10=1'b0;s11=1'b0;
		unique case (face_q)
			3'd0: begin
				s0=nbh_bit(nbh_q,2,2,1);s1=nbh_bit(nbh_q,2,1,2);s2=nbh_bit(nbh_q,2,2,2);
				s3=nbh_bit(nbh_q,2,1,2);s4=nbh_bit(nbh_q,2,0,1);s5=nbh_bit(nbh_q,2,0,2);
				s6=nbh_bit(nbh_q,2,1,0);s7=nbh_bit(nbh_q,2,0,1);s8=nbh_bit(nbh_q,2,0,0);
				s9=nbh_bit(nbh_q,2,2,1);s10=nbh_bit(nbh_q,2,1,0);s11=nbh_bit(nbh_q,2,2,0);
			end
			3'd1: begin
				s0=nbh_bit(nbh_q,0,2,1);s1=nbh_bit(nbh_q,0,1,0);s2=nbh_bit(nbh_q,0,2,0);
				s3=nbh_bit(nbh_q,0,1,0);s4=nbh_bit(nbh_q,0,0,1);s5=nbh_bit(nbh_q,0,0,0);
				s6=nbh_bit(nbh_q,0,1,2);s7=nbh_bit(nbh_q,0,0,1);s8=nbh_bit(nbh_q,0,0,2);
				s9=nbh_bit(nbh_q,0,2,1);s10=nbh_bit(nbh_q,0,1,2);s11=nbh_bit(nbh_q,0,2,2);
			end
			3'd2: begin
				s0=nbh_bit(nbh_q,0,2,1);s1=nbh_bit(nbh_q,1,2,0);s2=nbh_bit(nbh_q,0,2,0);
				s3=nbh_bit(nbh_q,0,2,1);s4=nbh_bit(nbh_q,1,2,2);s5=nbh_bit(nbh_q,0,2,2);
				s6=nbh_bit(nbh_q,2,2,1);s7=nbh_bit(nbh_q,1,2,2);s8=nbh_bit(nbh_q,2,2,2);
				s9=nbh_bit(nbh_q,2,2,1);s10=nbh_bit(nbh_q,1,2,0);s11=nbh_bit(nbh_q,2,2,0);
			end
			3'd3: begin
				s0=nbh_bit(nbh_q,0,0,1);s1=nbh_bit(nbh_q,1,0,2);s2=nbh_bit(nbh_q,0,0,2);
				s3=nbh_bit(nbh_q,0,0,1);s4=nbh_bit(nbh_q,1,0,0);s5=nbh_bit(nbh_q,0,0,0);
				s6=nbh_bit(nbh_q,2,0,1);s7=nbh_bit(nbh_q,1,0,0);s8=nbh_bit(nbh_q,2,0,0);
				s9=nbh_bit(nbh_q,2,0,1);s10=nbh_bit(nbh_q,1,0,2);s11=nbh_bit(nbh_q,2,0,2);
			end
			3'd4: begin
				s0=nbh_bit(nbh_q,0,1,2);s1=nbh_bit(nbh_q,1,2,2);s2=nbh_bit(nbh_q,0,2,2);
				s3=nbh_bit(nbh_q,0,1,2);s4=nbh_bit(nbh_q,1,0,2);s5=nbh_bit(nbh_q,0,0,2);
				s6=nbh_bit(nbh_q,2,1,2);s7=nbh_bit(nbh_q,1,0,2);s8=nbh_bit(nbh_q,2,0,2);
				s9=nbh_bit(nbh_q,2,1,2);s10=nbh_bit(nbh_q,1,2,2);s11=nbh_bit(nbh_q,2,2,2);
			end
			default: begin
				s0=nbh_bit(nbh_q,2,1,0);s1=nbh_bit(nbh_q,1,2,0);s2=nbh_bit(nbh_q,2,2,0);
				s3=nbh_bit(nbh_q,2,1,0);s4=nbh_bit(nbh_q,1,0,0);s5=nbh_bit(nbh_q,2,0,0);
				s6=nbh_bit(nbh_q,0,1,0);s7=nbh_bit(nbh_q,1,0,0);s8=nbh_bit(nbh_q,0,0,0);
				s9=nbh_bit(nbh_q,0,1,0);s10=nbh_bit(nbh_q,1,2,0);s11=nbh_bit(nbh_q,0,2,0);
			end
		endcase
		l0 = ao_lvl(s0, s1, s2);
		l1 = ao_lvl(s3, s4, s5);
		l2 = ao_lvl(s6, s7, s8);
		l3 = ao_lvl(s9, s10, s11);
	end

	logic [5:0] exposed;
	assign exposed = {~nbh_bit(nbh_q,1,1,0), ~nbh_bit(nbh_q,1,1,2), ~nbh_bit(nbh_q,1,0,1),
		~nbh_bit(nbh_q,1,2,1), ~nbh_bit(nbh_q,0,1,1), ~nbh_bit(nbh_q,2,1,1)};

	logic [5:0] rest;
	assign rest = todo_q & ~(6'd1 << face_q);

	logic [2:0] nxt_face;
	always_comb begin
		nxt_face = 3'd0;
		for (int i = 5; i >= 0; i--) if (rest[i]) nxt_face = 3'(i);
	end
	logic [2:0] first_face;
	always_comb begin
		first_face = 3'd0;
		for (int i = 5; i >= 0; i--) if (exposed[i]) first_face = 3'(i);
	end

	logic out_free;
	assign out_free = !valid || !stall;
	assign q_pop = (state_q == S_IDLE) && q_valid;

	logic emit;
	assign emit = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		if (state_q == S_READ && rcnt_q != 4'd0) begin
			nbh_q[prev*3 +: 3] <= bits3;
		end
		if (emit) begin
			face_id         <= face_q;
			ao_top_left     <= l0;
			ao_bottom_left  <= l1;
			ao_bottom_right <= l2;
			ao_top_right    <= l3;
			split_flip      <= ({1'b0,l0} + {1'b0,l2}) > ({1'b0,l1} + {1'b0,l3});
			face_x          <= cmd_q.x;
			face_y          <= cmd_q.y;
			face_z          <= cmd_q.z;
			last_face       <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			rcnt_q  <= '0;
			todo_q  <= '0;
			face_q  <= '0;
			valid   <= 1'b0;
		end else begin
			if (emit) begin
				valid <= 1'b1;
			end else if (!stall) begin
				valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == AddrW'(RowDepth-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					rcnt_q <= '0;
					if (q_valid) state_q <= q_cmd.mesh ? S_READ : S_WRMOD;
				end
				S_WRMOD: state_q <= S_IDLE;
				S_READ: begin
					rcnt_q <= rcnt_q + 4'd1;
					if (rcnt_q == 4'd9) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!nbh_bit(nbh_q,1,1,1) || exposed == '0) begin
						state_q <= S_IDLE;
					end else begin
						todo_q  <= exposed;
						face_q  <= first_face;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						todo_q <= rest;
						face_q <= nxt_face;
						if (rest == '0) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/voxel_face_cull_ambient_occlusion.sv -----
// voxel_face_cull_ambient_occlusion: top level, front queue plus back engine.
// Depends on vfcao_pkg, vfcao_front, vfcao_back.
//
//  channel | direction | handshake     | fields
//  in      | in        | valid / stall | mode, vox_x, vox_y, vox_z, filled
//  out     | out       | valid / stall | face_id, ao_*, split_flip, face_*, last_face
//
// Writes are a read-modify-write of one occupancy row in the back end.
// Mesh requests gather nine rows through the single RAM port, then check the voxel
//   and emit each exposed face in turn; the nine row reads set the pace.
// Off-grid writes and off-chunk requests are dropped at the front.
// After reset the back end clears 324 rows, one per cycle, before taking words;
//   the front queue still holds two words meanwhile.
// Output stall holds the result register; the two-word queue lets input run ahead.
module voxel_face_cull_ambient_occlusion (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [4:0] vox_x,
	input  logic [4:0] vox_y,
	input  logic [4:0] vox_z,
	input  logic       filled,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] face_id,
	output logic [1:0] ao_top_left,
	output logic [1:0] ao_bottom_left,
	output logic [1:0] ao_bottom_right,
	output logic [1:0] ao_top_right,
	output logic       split_flip,
	output logic [4:0] face_x,
	output logic [4:0] face_y,
	output logic [4:0] face_z,
	output logic       last_face
);
	import vfcao_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_cmd;

	// front: filter and queue words
	vfcao_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.mode(mode), .vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z), .filled(filled),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	// back: occupancy store and face emission
	vfcao_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
		.valid(out_valid), .stall(out_stall), .face_id(face_id),
		.ao_top_left(ao_top_left), .ao_bottom_left(ao_bottom_left),
		.ao_bottom_right(ao_bottom_right), .ao_top_right(ao_top_right),
		.split_flip(split_flip), .face_x(face_x), .face_y(face_y), .face_z(face_z),
		.last_face(last_face)
	);
endmodule
